>>> rtl/mirrored_record_checksum_repair_assert.svh
// Assertion macros shared by the mirrored record checksum repair RTL.
`ifndef MIRRORED_RECORD_CHECKSUM_REPAIR_ASSERT_SVH
`define MIRRORED_RECORD_CHECKSUM_REPAIR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MRCR_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mrcr assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define MRCR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mrcr assertion failed");

`endif

>>> rtl/mrcr_pkg.sv
// Types, codes and microcode ROM for the mirrored record checksum repair block.
package mrcr_pkg;

	localparam int STORE_BYTES = 1024;
	localparam int ADDR_W      = $clog2(STORE_BYTES);
	localparam int BASE_W      = 10;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 10;
	localparam int PC_W        = 6;

	localparam logic [7:0] SUM_SEED  = 8'h01;
	localparam logic [7:0] FILL_BYTE = 8'hFF;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PRIMARY_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BACKUP_BASE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RECORD_LENGTH = 2'd2;

	// item operations
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_CHECK = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// check outcomes
	localparam logic [2:0] STAT_OK          = 3'd0;
	localparam logic [2:0] STAT_FIX_PRIMARY = 3'd1;
	localparam logic [2:0] STAT_FIX_BACKUP  = 3'd2;
	localparam logic [2:0] STAT_RESET       = 3'd3;
	localparam logic [2:0] STAT_OVERWRITE   = 3'd4;

	// control word field codes
	localparam logic [1:0] MEM_NONE = 2'd0;
	localparam logic [1:0] MEM_RD   = 2'd1;
	localparam logic [1:0] MEM_WR   = 2'd2;

	localparam logic BASE_P = 1'b0;
	localparam logic BASE_B = 1'b1;

	localparam logic [1:0] OFF_CNT  = 2'd0;
	localparam logic [1:0] OFF_IDX  = 2'd1;
	localparam logic [1:0] OFF_IDX1 = 2'd2;

	localparam logic [2:0] WD_DATA = 3'd0;
	localparam logic [2:0] WD_WSUM = 3'd1;
	localparam logic [2:0] WD_LAT  = 3'd2;
	localparam logic [2:0] WD_FILL = 3'd3;
	localparam logic [2:0] WD_SUMB = 3'd4;
	localparam logic [2:0] WD_SUMP = 3'd5;

	localparam logic [1:0] CNT_KEEP = 2'd0;
	localparam logic [1:0] CNT_CLR  = 2'd1;
	localparam logic [1:0] CNT_INC  = 2'd2;

	localparam logic [1:0] ACC_KEEP = 2'd0;
	localparam logic [1:0] ACC_SEED = 2'd1;
	localparam logic [1:0] ACC_ADD  = 2'd2;

	localparam logic [1:0] LAT_NONE = 2'd0;
	localparam logic [1:0] LAT_WR   = 2'd1;
	localparam logic [1:0] LAT_RD   = 2'd2;

	localparam logic [1:0] SAVE_NONE = 2'd0;
	localparam logic [1:0] SAVE_P    = 2'd1;
	localparam logic [1:0] SAVE_B    = 2'd2;

	localparam logic [3:0] COND_NONE     = 4'd0;
	localparam logic [3:0] COND_ALWAYS   = 4'd1;
	localparam logic [3:0] COND_EQ_LEN   = 4'd2;
	localparam logic [3:0] COND_NE_LEN   = 4'd3;
	localparam logic [3:0] COND_NOT_LAST = 4'd4;
	localparam logic [3:0] COND_NEITHER  = 4'd5;
	localparam logic [3:0] COND_ONLY_B   = 4'd6;
	localparam logic [3:0] COND_ONLY_P   = 4'd7;
	localparam logic [3:0] COND_SUMS_EQ  = 4'd8;

	localparam logic [1:0] RES_PLAIN = 2'd0;
	localparam logic [1:0] RES_READ  = 2'd1;
	localparam logic [1:0] RES_CHECK = 2'd2;

	// microprogram addresses
	localparam logic [PC_W-1:0] UPC_WRITE   = 6'd0;
	localparam logic [PC_W-1:0] UPC_WEND    = 6'd4;
	localparam logic [PC_W-1:0] UPC_READ    = 6'd5;
	localparam logic [PC_W-1:0] UPC_CHECK   = 6'd7;
	localparam logic [PC_W-1:0] UPC_PLOOP   = 6'd8;
	localparam logic [PC_W-1:0] UPC_PDONE   = 6'd10;
	localparam logic [PC_W-1:0] UPC_BLOOP   = 6'd11;
	localparam logic [PC_W-1:0] UPC_BDONE   = 6'd13;
	localparam logic [PC_W-1:0] UPC_FIXP    = 6'd19;
	localparam logic [PC_W-1:0] UPC_CPLOOP  = 6'd20;
	localparam logic [PC_W-1:0] UPC_CPDONE  = 6'd22;
	localparam logic [PC_W-1:0] UPC_FIXB    = 6'd23;
	localparam logic [PC_W-1:0] UPC_RPLOOP  = 6'd24;
	localparam logic [PC_W-1:0] UPC_RPDONE  = 6'd26;
	localparam logic [PC_W-1:0] UPC_WBLOOP  = 6'd27;
	localparam logic [PC_W-1:0] UPC_WBDONE  = 6'd29;
	localparam logic [PC_W-1:0] UPC_NEITHER = 6'd30;
	localparam logic [PC_W-1:0] UPC_FPLOOP  = 6'd31;
	localparam logic [PC_W-1:0] UPC_FBLOOP  = 6'd33;
	localparam logic [PC_W-1:0] UPC_CEND    = 6'd34;

	typedef struct packed {
		logic [1:0]      mem;
		logic            base_sel;
		logic [1:0]      off_sel;
		logic [2:0]      wd_sel;
		logic [1:0]      cnt_op;
		logic [1:0]      acc_op;
		logic [1:0]      lat_op;
		logic [1:0]      save;
		logic            wsum_upd;
		logic            stat_set;
		logic [2:0]      stat;
		logic [3:0]      cond;
		logic [PC_W-1:0] target;
		logic            fin;
		logic [1:0]      res;
	} uop_t;

	typedef struct packed {
		logic eq_len;
		logic not_last;
		logic ok_p;
		logic ok_b;
		logic sums_eq;
	} flags_t;

	function automatic logic [PC_W-1:0] entry_of(input logic [1:0] op);
		logic [PC_W-1:0] e;
		unique case (op)
			OP_WRITE: e = UPC_WRITE;
			OP_CHECK: e = UPC_CHECK;
			OP_READ:  e = UPC_READ;
			default:  e = UPC_WEND;
		endcase
		return e;
	endfunction

	function automatic uop_t ucode(input logic [PC_W-1:0] pc);
		uop_t u;
		u = '0;
		unique case (pc)
			// write: byte to both copies, then the sum after both on the last byte
			6'd0: begin
				u.wsum_upd = 1'b1; u.mem = MEM_WR; u.base_sel = BASE_P;
				u.off_sel = OFF_IDX; u.wd_sel = WD_DATA;
			end
			6'd1: begin
				u.mem = MEM_WR; u.base_sel = BASE_B; u.off_sel = OFF_IDX; u.wd_sel = WD_DATA;
				u.cond = COND_NOT_LAST; u.target = UPC_WEND;
			end
			6'd2: begin
				u.mem = MEM_WR; u.base_sel = BASE_P; u.off_sel = OFF_IDX1; u.wd_sel = WD_WSUM;
			end
			6'd3: begin
				u.mem = MEM_WR; u.base_sel = BASE_B; u.off_sel = OFF_IDX1; u.wd_sel = WD_WSUM;
				u.fin = 1'b1; u.res = RES_PLAIN;
			end
			6'd4: begin
				u.fin = 1'b1; u.res = RES_PLAIN;
			end
			// read
			6'd5: begin
				u.mem = MEM_RD; u.base_sel = BASE_B; u.off_sel = OFF_IDX;
			end
			6'd6: begin
				u.fin = 1'b1; u.res = RES_READ;
			end
			// check: sum the primary copy
			6'd7: begin
				u.cnt_op = CNT_CLR; u.acc_op = ACC_SEED;
			end
			6'd8: begin
				u.mem = MEM_RD; u.base_sel = BASE_P; u.off_sel = OFF_CNT;
				u.cond = COND_EQ_LEN; u.target = UPC_PDONE;
			end
			6'd9: begin
				u.acc_op = ACC_ADD; u.cnt_op = CNT_INC;
				u.cond = COND_ALWAYS; u.target = UPC_PLOOP;
			end
			6'd10: begin
				u.save = SAVE_P; u.cnt_op = CNT_CLR; u.acc_op = ACC_SEED;
			end
			// sum and latch the backup copy
			6'd11: begin
				u.mem = MEM_RD; u.base_sel = BASE_B; u.off_sel = OFF_CNT;
				u.cond = COND_EQ_LEN; u.target = UPC_BDONE;
			end
			6'd12: begin
				u.acc_op = ACC_ADD; u.lat_op = LAT_WR; u.cnt_op = CNT_INC;
				u.cond = COND_ALWAYS; u.target = UPC_BLOOP;
			end
			6'd13: begin
				u.save = SAVE_B; u.cnt_op = CNT_CLR; u.stat_set = 1'b1; u.stat = STAT_OK;
			end
			// pick the repair
			6'd14: begin
				u.cond = COND_NEITHER; u.target = UPC_NEITHER;
			end
			6'd15: begin
				u.cond = COND_ONLY_B; u.target = UPC_FIXP;
			end
			6'd16: begin
				u.cond = COND_ONLY_P; u.target = UPC_FIXB;
			end
			6'd17: begin
				u.cond = COND_SUMS_EQ; u.target = UPC_CEND;
			end
			6'd18: begin
				u.stat_set = 1'b1; u.stat = STAT_OVERWRITE;
				u.cond = COND_ALWAYS; u.target = UPC_CPLOOP;
			end
			6'd19: begin
				u.stat_set = 1'b1; u.stat = STAT_FIX_PRIMARY;
			end
			// latched backup bytes over the primary copy
			6'd20: begin
				u.lat_op = LAT_RD; u.cond = COND_EQ_LEN; u.target = UPC_CPDONE;
			end
			6'd21: begin
				u.mem = MEM_WR; u.base_sel = BASE_P; u.off_sel = OFF_CNT; u.wd_sel = WD_LAT;
				u.cnt_op = CNT_INC; u.cond = COND_ALWAYS; u.target = UPC_CPLOOP;
			end
			6'd22: begin
				u.mem = MEM_WR; u.base_sel = BASE_P; u.off_sel = OFF_CNT; u.wd_sel = WD_SUMB;
				u.fin = 1'b1; u.res = RES_CHECK;
			end
			// re-read the primary copy, then write it over the backup copy
			6'd23: begin
				u.stat_set = 1'b1; u.stat = STAT_FIX_BACKUP;
			end
			6'd24: begin
				u.mem = MEM_RD; u.base_sel = BASE_P; u.off_sel = OFF_CNT;
				u.cond = COND_EQ_LEN; u.target = UPC_RPDONE;
			end
			6'd25: begin
				u.lat_op = LAT_WR; u.cnt_op = CNT_INC;
				u.cond = COND_ALWAYS; u.target = UPC_RPLOOP;
			end
			6'd26: begin
				u.cnt_op = CNT_CLR;
			end
			6'd27: begin
				u.lat_op = LAT_RD; u.cond = COND_EQ_LEN; u.target = UPC_WBDONE;
			end
			6'd28: begin
				u.mem = MEM_WR; u.base_sel = BASE_B; u.off_sel = OFF_CNT; u.wd_sel = WD_LAT;
				u.cnt_op = CNT_INC; u.cond = COND_ALWAYS; u.target = UPC_WBLOOP;
			end
			6'd29: begin
				u.mem = MEM_WR; u.base_sel = BASE_B; u.off_sel = OFF_CNT; u.wd_sel = WD_SUMP;
				u.fin = 1'b1; u.res = RES_CHECK;
			end
			// fill both copies, checksum bytes included
			6'd30: begin
				u.stat_set = 1'b1; u.stat = STAT_RESET;
			end
			6'd31: begin
				u.mem = MEM_WR; u.base_sel = BASE_P; u.off_sel = OFF_CNT; u.wd_sel = WD_FILL;
				u.cnt_op = CNT_INC; u.cond = COND_NE_LEN; u.target = UPC_FPLOOP;
			end
			6'd32: begin
				u.cnt_op = CNT_CLR;
			end
			6'd33: begin
				u.mem = MEM_WR; u.base_sel = BASE_B; u.off_sel = OFF_CNT; u.wd_sel = WD_FILL;
				u.cnt_op = CNT_INC; u.cond = COND_NE_LEN; u.target = UPC_FBLOOP;
			end
			6'd34: begin
				u.fin = 1'b1; u.res = RES_CHECK;
			end
			default: begin
				u.fin = 1'b1; u.res = RES_PLAIN;
			end
		endcase
		return u;
	endfunction

endpackage

>>> rtl/mrcr_in_if.sv
// Input item channel: valid/ready with the item fields.
interface mrcr_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] data_in;
	logic [7:0] byte_index;
	logic       last;

	modport source (output valid, op, data_in, byte_index, last, input ready);
	modport sink (input valid, op, data_in, byte_index, last, output ready);
endinterface

>>> rtl/mrcr_out_if.sv
// Result channel: valid/ready with the result fields.
interface mrcr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_out;
	logic [2:0] check_status;
	logic       status_valid;

	modport source (output valid, data_out, check_status, status_valid, input ready);
	modport sink (input valid, data_out, check_status, status_valid, output ready);
endinterface

>>> rtl/mrcr_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
interface mrcr_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [mrcr_pkg::CFG_IDX_W-1:0]     index;
	logic [mrcr_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/mirrored_record_checksum_repair.sv
// Mirrored record checksum repair: top level with store, latch buffer and datapath.
//
// Usage:
// - item channel takes one operation at a time: op 0 writes data_in at byte_index into both
//   copies (and the running checksum after both when last is set), op 1 checks and repairs
//   the two copies, op 2 reads one byte of the backup copy. Op 3 does nothing.
// - result channel returns exactly one transfer per item, in order.
// - cfg channel writes primary_base, backup_base and record_length; it is always ready and
//   must only be used while no item is in flight.
// Sequencing: a microcoded sequencer steps through the operation, one store access per step,
// since the byte store has a single port with registered read data.
// A new item is taken as soon as the sequencer is idle, even while the previous result
// still waits in the output register. When the receiver stalls, the last step of the
// next item holds until the output register frees.
// Reset clears the sequencer, the output register, the running write checksum (to 1) and
// the configuration registers (0, 512, 24). Store contents are not reset.
`include "mirrored_record_checksum_repair_assert.svh"

module mirrored_record_checksum_repair (
	input  logic        clk,
	input  logic        arst_n,
	mrcr_in_if.sink     item,
	mrcr_out_if.source  result,
	mrcr_cfg_if.sink    cfg
);

	logic [mrcr_pkg::BASE_W-1:0] pbase_q;
	logic [mrcr_pkg::BASE_W-1:0] bbase_q;
	logic [7:0]                  len_q;
	logic [7:0]                  wsum_q;

	logic [7:0]                  data_q;
	logic [7:0]                  idx_q;
	logic                        last_q;

	logic [7:0]                  cnt_q;
	logic [7:0]                  acc_q;
	logic [7:0]                  sum_p_q;
	logic [7:0]                  sum_b_q;
	logic                        ok_p_q;
	logic                        ok_b_q;
	logic [2:0]                  stat_q;

	logic [7:0]                  store_q [mrcr_pkg::STORE_BYTES];
	logic [7:0]                  store_rd_q;
	logic [7:0]                  lat_q [256];
	logic [7:0]                  lat_rd_q;

	logic                        res_valid_q;
	logic [7:0]                  res_data_q;
	logic [2:0]                  res_stat_q;
	logic                        res_sv_q;

	mrcr_pkg::uop_t              uop;
	mrcr_pkg::flags_t            flags;
	logic                        busy;
	logic                        start;
	logic                        stall;
	logic                        step_en;
	logic [8:0]                  off;
	logic [mrcr_pkg::BASE_W-1:0] base;
	logic [mrcr_pkg::BASE_W:0]   addr_sum;
	logic [mrcr_pkg::ADDR_W-1:0] addr;
	logic [7:0]                  wdata;
	logic                        mem_we;
	logic                        mem_re;

	assign item.ready = !busy;
	assign start      = item.valid && item.ready;
	// hold the final step while the previous result has not been taken
	assign stall      = uop.fin && res_valid_q && !result.ready;
	assign step_en    = busy && !stall;

	assign flags.eq_len   = (cnt_q == len_q);
	assign flags.not_last = !last_q;
	assign flags.ok_p     = ok_p_q;
	assign flags.ok_b     = ok_b_q;
	assign flags.sums_eq  = (sum_p_q == sum_b_q);

	mrcr_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (item.op),
		.stall  (stall),
		.flags  (flags),
		.uop    (uop),
		.busy   (busy)
	);

	// address: base plus offset, wrapping around the store
	always_comb begin
		unique case (uop.off_sel)
			mrcr_pkg::OFF_CNT:  off = {1'b0, cnt_q};
			mrcr_pkg::OFF_IDX:  off = {1'b0, idx_q};
			mrcr_pkg::OFF_IDX1: off = {1'b0, idx_q} + 9'd1;
			default:            off = '0;
		endcase
	end

	assign base     = (uop.base_sel == mrcr_pkg::BASE_B) ? bbase_q : pbase_q;
	assign addr_sum = {1'b0, base} + {{(mrcr_pkg::BASE_W - 8){1'b0}}, off};
	assign addr     = addr_sum[mrcr_pkg::ADDR_W-1:0];

	always_comb begin
		unique case (uop.wd_sel)
			mrcr_pkg::WD_DATA: wdata = data_q;
			mrcr_pkg::WD_WSUM: wdata = wsum_q;
			mrcr_pkg::WD_LAT:  wdata = lat_rd_q;
			mrcr_pkg::WD_FILL: wdata = mrcr_pkg::FILL_BYTE;
			mrcr_pkg::WD_SUMB: wdata = sum_b_q;
			mrcr_pkg::WD_SUMP: wdata = sum_p_q;
			default:           wdata = '0;
		endcase
	end

	assign mem_we = step_en && (uop.mem == mrcr_pkg::MEM_WR);
	assign mem_re = step_en && (uop.mem == mrcr_pkg::MEM_RD);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_q[addr] <= wdata;
		end
		if (mem_re) begin
			store_rd_q <= store_q[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && uop.lat_op == mrcr_pkg::LAT_WR) begin
			lat_q[cnt_q] <= store_rd_q;
		end
		if (step_en && uop.lat_op == mrcr_pkg::LAT_RD) begin
			lat_rd_q <= lat_q[cnt_q];
		end
	end

	// capture the item
	always_ff @(posedge clk) begin
		if (start) begin
			data_q <= item.data_in;
			idx_q  <= item.byte_index;
			last_q <= item.last;
		end
	end

	// loop counter, sums and check flags
	always_ff @(posedge clk) begin
		if (step_en) begin
			unique case (uop.cnt_op)
				mrcr_pkg::CNT_CLR: cnt_q <= '0;
				mrcr_pkg::CNT_INC: cnt_q <= cnt_q + 8'd1;
				default:           cnt_q <= cnt_q;
			endcase
			unique case (uop.acc_op)
				mrcr_pkg::ACC_SEED: acc_q <= mrcr_pkg::SUM_SEED;
				mrcr_pkg::ACC_ADD:  acc_q <= acc_q + store_rd_q;
				default:            acc_q <= acc_q;
			endcase
			// the checksum byte was read on the loop exit step
			if (uop.save == mrcr_pkg::SAVE_P) begin
				sum_p_q <= acc_q;
				ok_p_q  <= (store_rd_q == acc_q);
			end
			if (uop.save == mrcr_pkg::SAVE_B) begin
				sum_b_q <= acc_q;
				ok_b_q  <= (store_rd_q == acc_q);
			end
			if (uop.stat_set) begin
				stat_q <= uop.stat;
			end
		end
	end

	// configuration and running write checksum
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pbase_q <= 10'd0;
			bbase_q <= 10'd512;
			len_q   <= 8'd24;
			wsum_q  <= mrcr_pkg::SUM_SEED;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					mrcr_pkg::REG_PRIMARY_BASE:  pbase_q <= cfg.data[mrcr_pkg::BASE_W-1:0];
					mrcr_pkg::REG_BACKUP_BASE:   bbase_q <= cfg.data[mrcr_pkg::BASE_W-1:0];
					mrcr_pkg::REG_RECORD_LENGTH: len_q   <= cfg.data[7:0];
					default: begin
					end
				endcase
			end
			if (step_en && uop.wsum_upd) begin
				// restart the sum at the first byte
				wsum_q <= ((idx_q == 8'd0) ? mrcr_pkg::SUM_SEED : wsum_q) + data_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step_en && uop.fin) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && uop.fin) begin
			res_data_q <= (uop.res == mrcr_pkg::RES_READ) ? store_rd_q : 8'd0;
			res_stat_q <= (uop.res == mrcr_pkg::RES_CHECK) ? stat_q : mrcr_pkg::STAT_OK;
			res_sv_q   <= (uop.res == mrcr_pkg::RES_CHECK);
		end
	end

	assign result.valid        = res_valid_q;
	assign result.data_out     = res_data_q;
	assign result.check_status = res_stat_q;
	assign result.status_valid = res_sv_q;

	`MRCR_ASSERT_NEXT(a_accept_starts, start, busy)
	`MRCR_ASSERT_IMPL(a_status_range, result.valid && result.status_valid, result.check_status <= mrcr_pkg::STAT_OVERWRITE)
	`MRCR_ASSERT_IMPL(a_plain_status, result.valid && !result.status_valid, result.check_status == mrcr_pkg::STAT_OK)
	`MRCR_ASSERT_IMPL(a_latch_in_record, step_en && uop.lat_op == mrcr_pkg::LAT_WR, cnt_q < len_q)

endmodule

>>> rtl/mrcr_seq.sv
// Microcode sequencer: step counter, control ROM fetch and conditional jumps.
module mrcr_seq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [1:0]                op,
	input  logic                      stall,
	input  mrcr_pkg::flags_t          flags,
	output mrcr_pkg::uop_t            uop,
	output logic                      busy
);

	logic [mrcr_pkg::PC_W-1:0] pc_q;
	logic                      busy_q;
	logic                      take;

	assign uop  = mrcr_pkg::ucode(pc_q);
	assign busy = busy_q;

	always_comb begin
		unique case (uop.cond)
			mrcr_pkg::COND_NONE:     take = 1'b0;
			mrcr_pkg::COND_ALWAYS:   take = 1'b1;
			mrcr_pkg::COND_EQ_LEN:   take = flags.eq_len;
			mrcr_pkg::COND_NE_LEN:   take = !flags.eq_len;
			mrcr_pkg::COND_NOT_LAST: take = flags.not_last;
			mrcr_pkg::COND_NEITHER:  take = !flags.ok_p && !flags.ok_b;
			mrcr_pkg::COND_ONLY_B:   take = flags.ok_b && !flags.ok_p;
			mrcr_pkg::COND_ONLY_P:   take = flags.ok_p && !flags.ok_b;
			mrcr_pkg::COND_SUMS_EQ:  take = flags.sums_eq;
			default:                 take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			pc_q   <= mrcr_pkg::entry_of(op);
		end else if (busy_q && !stall) begin
			if (uop.fin) begin
				busy_q <= 1'b0;
			end else if (take) begin
				pc_q <= uop.target;
			end else begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

endmodule

>>> tb/tb_mirrored_record_checksum_repair.sv
`timescale 1ns / 1ps
// Testbench for the mirrored record checksum repair block: scoreboard, drivers and random phases.
module tb_mirrored_record_checksum_repair;

	localparam int BASE_W     = mrcr_pkg::BASE_W;
	localparam int CFG_IDX_W  = mrcr_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = mrcr_pkg::CFG_DATA_W;

	localparam logic [1:0]           OP_UNUSED  = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int                   SHOW_LIMIT = 10;
	localparam int                   ITEM_GOAL  = 700;

	typedef struct packed {
		logic [7:0] data_out;
		logic [2:0] check_status;
		logic       status_valid;
	} reply_t;

	class mirrored_record_tracker;
		logic [7:0]        mem [mrcr_pkg::STORE_BYTES];
		logic [7:0]        hold_buf [256];
		logic [BASE_W-1:0] primary_base, backup_base;
		logic [7:0]        record_length, write_sum;
		reply_t            replies_due [$];
		int                mismatches, matched;
		int                status_seen [5];
		int                op_seen [4];

		function new();
			primary_base = '0;
			backup_base = 10'd512;
			record_length = 8'd24;
			write_sum = mrcr_pkg::SUM_SEED;
			mismatches = 0;
			matched = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
			foreach (op_seen[i]) op_seen[i] = 0;
			foreach (mem[i]) mem[i] = '0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			case (index)
				mrcr_pkg::REG_PRIMARY_BASE:  primary_base = data[BASE_W-1:0];
				mrcr_pkg::REG_BACKUP_BASE:   backup_base = data[BASE_W-1:0];
				mrcr_pkg::REG_RECORD_LENGTH: record_length = data[7:0];
				default: ;
			endcase
		endfunction

		function int unsigned addr_at(logic [BASE_W-1:0] base, int unsigned off);
			return (int'(base) + off) % mrcr_pkg::STORE_BYTES;
		endfunction

		// Sum one copy; optionally keep its bytes in the hold buffer.
		function logic [7:0] copy_sum(logic [BASE_W-1:0] base, int unsigned len, bit grab);
			logic [7:0] s;
			logic [7:0] b;
			s = mrcr_pkg::SUM_SEED;
			for (int unsigned i = 0; i < len; i++) begin
				b = mem[addr_at(base, i)];
				if (grab)
					hold_buf[i] = b;
				s = s + b;
			end
			return s;
		endfunction

		function void copy_out(logic [BASE_W-1:0] base, int unsigned len, logic [7:0] sum);
			for (int unsigned i = 0; i < len; i++)
				mem[addr_at(base, i)] = hold_buf[i];
			mem[addr_at(base, len)] = sum;
		endfunction

		function logic [2:0] repair();
			int unsigned len;
			logic [7:0]  sum_p, sum_b;
			logic        ok_p, ok_b;
			len = record_length;
			sum_p = copy_sum(primary_base, len, 1'b0);
			sum_b = copy_sum(backup_base, len, 1'b1);
			ok_b = (mem[addr_at(backup_base, len)] == sum_b);
			ok_p = (mem[addr_at(primary_base, len)] == sum_p);
			if (!ok_b && !ok_p) begin
				foreach (hold_buf[i]) hold_buf[i] = mrcr_pkg::FILL_BYTE;
				copy_out(primary_base, len, mrcr_pkg::FILL_BYTE);
				copy_out(backup_base, len, mrcr_pkg::FILL_BYTE);
				return mrcr_pkg::STAT_RESET;
			end
			if (ok_b && !ok_p) begin
				copy_out(primary_base, len, sum_b);
				return mrcr_pkg::STAT_FIX_PRIMARY;
			end
			if (!ok_b && ok_p) begin
				// re-read the primary before it goes over the backup
				void'(copy_sum(primary_base, len, 1'b1));
				copy_out(backup_base, len, sum_p);
				return mrcr_pkg::STAT_FIX_BACKUP;
			end
			if (sum_b != sum_p) begin
				copy_out(primary_base, len, sum_b);
				return mrcr_pkg::STAT_OVERWRITE;
			end
			return mrcr_pkg::STAT_OK;
		endfunction

		function void take_item(logic [1:0] op, logic [7:0] data, logic [7:0] idx, logic last);
			reply_t r;
			r = '0;
			op_seen[op]++;
			case (op)
				mrcr_pkg::OP_WRITE: begin
					write_sum = (idx == 8'd0) ? mrcr_pkg::SUM_SEED + data : write_sum + data;
					mem[addr_at(primary_base, idx)] = data;
					mem[addr_at(backup_base, idx)] = data;
					if (last) begin
						mem[addr_at(primary_base, int'(idx) + 1)] = write_sum;
						mem[addr_at(backup_base, int'(idx) + 1)] = write_sum;
					end
				end
				mrcr_pkg::OP_CHECK: begin
					r.check_status = repair();
					r.status_valid = 1'b1;
					status_seen[r.check_status]++;
				end
				mrcr_pkg::OP_READ: begin
					r.data_out = mem[addr_at(backup_base, idx)];
				end
				default: ;
			endcase
			replies_due.push_back(r);
		endfunction

		function void match_reply(reply_t got);
			reply_t want;
			if (replies_due.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOW_LIMIT)
					$display("%0t: unexpected result: data_out=%02h status=%0d valid=%0b",
						$time, got.data_out, got.check_status, got.status_valid);
				return;
			end
			want = replies_due.pop_front();
			if (got.data_out !== want.data_out || got.check_status !== want.check_status ||
				got.status_valid !== want.status_valid) begin
				mismatches++;
				if (mismatches <= SHOW_LIMIT)
					$display("%0t: mismatch: data %02h/%02h status %0d/%0d valid %0b/%0b (exp/got)",
						$time, want.data_out, got.data_out, want.check_status, got.check_status,
						want.status_valid, got.status_valid);
			end else begin
				matched++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   send_steady, recv_steady;
	int   items_sent, cfg_writes;

	mrcr_in_if  item_ch ();
	mrcr_out_if result_ch ();
	mrcr_cfg_if cfg_ch ();

	mirrored_record_tracker tracker;

	mirrored_record_checksum_repair uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Caller is at a falling edge; return at the falling edge after the transfer.
	task automatic push_item(input logic [1:0] op, input logic [7:0] data, input logic [7:0] idx,
		input logic last);
		int gap;
		gap = send_steady ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			item_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.op = op;
		item_ch.data_in = data;
		item_ch.byte_index = idx;
		item_ch.last = last;
		item_ch.valid = 1'b1;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		tracker.take_item(op, data, idx, last);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		item_ch.valid = 1'b0;
		while (tracker.replies_due.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
		cfg_ch.index = index;
		cfg_ch.data = data;
		cfg_ch.valid = 1'b1;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		tracker.set_reg(index, data);
		cfg_writes++;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic set_layout(input logic [BASE_W-1:0] p, input logic [BASE_W-1:0] b,
		input logic [7:0] len);
		wait_drained();
		write_reg(mrcr_pkg::REG_PRIMARY_BASE, CFG_DATA_W'(p));
		write_reg(mrcr_pkg::REG_BACKUP_BASE, CFG_DATA_W'(b));
		write_reg(mrcr_pkg::REG_RECORD_LENGTH, CFG_DATA_W'(len));
	endtask

	task automatic write_record(input int len);
		int n;
		n = (len == 0) ? 1 : len;
		for (int i = 0; i < n; i++)
			push_item(mrcr_pkg::OP_WRITE, 8'($urandom_range(0, 255)), 8'(i), i == n - 1);
	endtask

	// Mostly aligned slots so records from earlier phases get paired up again.
	function automatic logic [BASE_W-1:0] pick_base();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return BASE_W'(128 * $urandom_range(0, 7));
		if (r == 6)
			return 10'd1023;
		if (r == 7)
			return 10'd1000;
		return BASE_W'($urandom_range(0, 1023));
	endfunction

	function automatic logic [7:0] pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return 8'd0;
		if (r < 70)
			return 8'($urandom_range(1, 8));
		if (r < 92)
			return 8'($urandom_range(9, 40));
		return 8'($urandom_range(41, 96));
	endfunction

	// result side: random stalls, check every transfer
	initial begin
		reply_t got;
		int     stall;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = recv_steady ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				result_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ch.ready = 1'b1;
			@(posedge clk);
			while (!result_ch.valid) @(posedge clk);
			got.data_out = result_ch.data_out;
			got.check_status = result_ch.check_status;
			got.status_valid = result_ch.status_valid;
			tracker.match_reply(got);
			@(negedge clk);
		end
	end

	initial begin
		#10_000_000;
		$display("tb_mirrored_record_checksum_repair: done, errors");
		$finish;
	end

	initial begin
		logic [BASE_W-1:0] p, b;
		logic [7:0]        len;
		int                phase, budget, r;
		tracker = new();
		item_ch.valid = 1'b0;
		item_ch.op = mrcr_pkg::OP_WRITE;
		item_ch.data_in = '0;
		item_ch.byte_index = '0;
		item_ch.last = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		send_steady = 1'b1;
		recv_steady = 1'b0;
		items_sent = 0;
		cfg_writes = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// preload the whole store, 256 bytes per copy and window
		for (int w = 0; w < 2; w++) begin
			set_layout(BASE_W'(w * 512), BASE_W'(w * 512 + 256), 8'd24);
			for (int i = 0; i < 255; i++)
				push_item(mrcr_pkg::OP_WRITE, 8'($urandom_range(0, 255)), 8'(i), i == 254);
		end

		// directed: one record byte per copy makes every repair outcome easy to set up
		send_steady = 1'b0;
		set_layout(10'd0, 10'd512, 8'd1);
		push_item(mrcr_pkg::OP_WRITE, 8'h00, 8'd0, 1'b1);
		push_item(mrcr_pkg::OP_CHECK, 8'h00, 8'd0, 1'b0);
		push_item(mrcr_pkg::OP_READ, 8'h00, 8'd0, 1'b0);
		push_item(mrcr_pkg::OP_READ, 8'h00, 8'd1, 1'b0);
		set_layout(10'd700, 10'd600, 8'd1);
		push_item(mrcr_pkg::OP_WRITE, 8'hFF, 8'd0, 1'b1);
		// both valid with different sums
		set_layout(10'd0, 10'd600, 8'd1);
		push_item(mrcr_pkg::OP_CHECK, 8'h00, 8'd0, 1'b0);
		// stale checksums on both sides, then fill
		set_layout(10'd0, 10'd512, 8'd1);
		push_item(mrcr_pkg::OP_WRITE, 8'h55, 8'd0, 1'b0);
		push_item(mrcr_pkg::OP_CHECK, 8'h00, 8'd0, 1'b0);
		set_layout(10'd0, 10'd700, 8'd1);
		push_item(mrcr_pkg::OP_CHECK, 8'h00, 8'd0, 1'b0);
		set_layout(10'd700, 10'd512, 8'd1);
		push_item(mrcr_pkg::OP_CHECK, 8'h00, 8'd0, 1'b0);
		// empty record, unused op, top index
		set_layout(10'd1023, 10'd0, 8'd0);
		push_item(mrcr_pkg::OP_CHECK, 8'h00, 8'd0, 1'b0);
		push_item(OP_UNUSED, 8'hFF, 8'hFF, 1'b1);
		push_item(mrcr_pkg::OP_READ, 8'h00, 8'hFF, 1'b0);
		wait_drained();
		write_reg(REG_UNUSED, '1);
		// longest record, copies overlap and wrap around the store
		set_layout(10'd1000, 10'd900, 8'd255);
		push_item(mrcr_pkg::OP_WRITE, 8'hFF, 8'hFF, 1'b1);
		push_item(mrcr_pkg::OP_CHECK, 8'h00, 8'd0, 1'b0);
		push_item(mrcr_pkg::OP_READ, 8'h00, 8'd254, 1'b0);

		// random phases, each with its own layout and idling mix
		phase = 0;
		while (items_sent < ITEM_GOAL) begin
			p = pick_base();
			b = ($urandom_range(0, 4) == 0) ? BASE_W'(p + $urandom_range(1, 8)) : pick_base();
			len = pick_length();
			budget = items_sent + 40;
			set_layout(p, b, len);
			send_steady = ($urandom_range(0, 3) == 0);
			recv_steady = ($urandom_range(0, 3) == 0);
			while (items_sent < budget) begin
				r = $urandom_range(0, 99);
				if (r < 40) begin
					write_record(len);
					if ($urandom_range(0, 1) == 1)
						push_item(mrcr_pkg::OP_CHECK, 8'($urandom_range(0, 255)),
							8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				end else if (r < 58) begin
					push_item(mrcr_pkg::OP_CHECK, 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				end else if (r < 78) begin
					push_item(mrcr_pkg::OP_READ, 8'($urandom_range(0, 255)),
						($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
						8'($urandom_range(0, len)), 1'($urandom_range(0, 1)));
				end else if (r < 92) begin
					push_item(mrcr_pkg::OP_WRITE, 8'($urandom_range(0, 255)),
						($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
						8'($urandom_range(0, len)), 1'($urandom_range(0, 1)));
				end else if (r < 97) begin
					push_item(OP_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
				end else begin
					// hold off until the block has caught up
					wait_drained();
				end
			end
			phase++;
		end

		item_ch.valid = 1'b0;
		while (tracker.replies_due.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);

		$display("covered %0d items, %0d random phases, %0d register writes; ops w/c/r/u: %0d/%0d/%0d/%0d",
			items_sent, phase, cfg_writes, tracker.op_seen[0], tracker.op_seen[1],
			tracker.op_seen[2], tracker.op_seen[3]);
		$display("check outcomes ok/fixp/fixb/reset/overwrite: %0d/%0d/%0d/%0d/%0d; %0d matched",
			tracker.status_seen[0], tracker.status_seen[1], tracker.status_seen[2],
			tracker.status_seen[3], tracker.status_seen[4], tracker.matched);
		if (tracker.mismatches == 0 && tracker.replies_due.size() == 0)
			$display("tb_mirrored_record_checksum_repair: done, clean");
		else
			$display("tb_mirrored_record_checksum_repair: done, errors");
		$finish;
	end

endmodule
